>>> rtl/sha256_pkg.sv
package sha256_pkg;

  localparam logic [5:0] PadPos = 6'd56;
  localparam logic [7:0] PadMark = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [5:0] waddr;
    logic       we;
    logic [7:0] wdata;
  } mem_ctl_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[t];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    init_hash = h[i];
  endfunction

endpackage

>>> rtl/sha256_core.sv
module sha256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  sha256_pkg::mem_ctl_t  ctl,
  input  logic                  fold,
  input  logic                  reinit,
  input  logic [2:0]            hidx,
  output logic [31:0]           hword,
  output logic                  busy
);
  import sha256_pkg::*;

  logic [7:0]  block_mem [64];
  logic [31:0] rd_word;
  logic [5:0]  rd_addr;
  logic [31:0] w [16];
  logic [31:0] s [8];
  logic [31:0] h [8];
  logic [6:0]  cnt;
  logic        run;
  logic        wphase;
  logic [1:0]  bsel;
  logic [7:0]  rd_byte;
  logic [31:0] wt, w16, s0w, s1w, sum1, ch, p, sum0, maj;
  logic [5:0]  rnd;

  always_ff @(posedge clk) begin
    if (ctl.we) block_mem[ctl.waddr] <= ctl.wdata;
    rd_byte <= block_mem[rd_addr];
  end

  assign rd_addr = cnt[5:0];
  assign busy = run;

  // load phase: cnt 0..64 streams 64 bytes; compress phase: 64 rounds
  always_comb begin
    s0w = ror32(w[1], 7) ^ ror32(w[1], 18) ^ (w[1] >> 3);
    s1w = ror32(w[14], 17) ^ ror32(w[14], 19) ^ (w[14] >> 10);
    w16 = w[0] + s0w + w[9] + s1w;
    wt = w[0];
    rnd = cnt[5:0];
    sum1 = ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25);
    ch = (s[4] & s[5]) ^ (~s[4] & s[6]);
    p = s[7] + sum1 + ch + round_k(rnd) + wt;
    sum0 = ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22);
    maj = (s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]);
  end

  assign rd_word = {w[15][23:0], rd_byte};
  assign hword = h[hidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      wphase <= 1'b0;
      cnt <= '0;
      bsel <= '0;
      for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
    end else begin
      if (reinit) begin
        for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
      end else if (fold) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] + s[i];
      end
      if (ctl.start) begin
        run <= 1'b1;
        wphase <= 1'b0;
        cnt <= '0;
        bsel <= '0;
      end else if (run && !wphase) begin
        cnt <= cnt + 7'd1;
        if (cnt != 7'd0) begin
          bsel <= bsel + 2'd1;
          if (bsel == 2'd0 && cnt != 7'd1) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          end
          w[15] <= rd_word;
        end
        if (cnt == 7'd64) begin
          wphase <= 1'b1;
          cnt <= '0;
          for (int i = 0; i < 8; i++) s[i] <= h[i];
        end
      end else if (run) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
        w[15] <= w16;
        s[7] <= s[6]; s[6] <= s[5]; s[5] <= s[4];
        s[4] <= s[3] + p;
        s[3] <= s[2]; s[2] <= s[1]; s[1] <= s[0];
        s[0] <= p + sum0 + maj;
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) run <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/sha256_byte_stream_hasher.sv
// Bytes without end of message are taken back to back; the 64th byte of a block then holds
// the input through the core's load and round phases, the done detection and the fold.
// End of message: 64 - fill pad writes and a compression; a last byte at 56..63 or at 64
// adds 64 more pad writes and a second compression. Then the eight digest words leave one
// per cycle while out_stall is low. The single block memory port and one-round core set the rate.
// Synchronous active-high reset restores the initial hash values and clears the counts.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  state_t      state, state_next;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [6:0]  pidx;
  logic        final_blk;
  logic        ret_idle;
  logic [2:0]  oidx;
  mem_ctl_t    ctl;
  logic        fold, reinit, take, core_busy, was_busy;
  logic [31:0] hword;

  sha256_core u_core (
    .clk(clk), .rst(rst), .ctl(ctl), .fold(fold), .reinit(reinit),
    .hidx(oidx), .hword(hword), .busy(core_busy)
  );

  assign take = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign digest_word = hword;
  assign word_index = oidx;
  assign last_word = (oidx == 3'd7);

  logic [7:0] pad_byte;
  always_comb begin
    if (final_blk && pidx[5:0] >= PadPos) pad_byte = bits[8'(7'd63 - pidx[5:0]) * 8 +: 8];
    else if (pidx[5:0] == fill) pad_byte = PadMark;
    else pad_byte = 8'h00;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    fold = 1'b0;
    reinit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (byte_valid) begin
            ctl.we = 1'b1;
            ctl.waddr = fill;
            ctl.wdata = data_byte;
          end
          if (byte_valid && fill == 6'd63) begin
            ctl.start = 1'b1;
            state_next = ST_COMP;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl.we = 1'b1;
        ctl.waddr = pidx[5:0];
        ctl.wdata = pad_byte;
        if (pidx == 7'd63) begin
          ctl.start = 1'b1;
          state_next = ST_COMP;
        end
      end
      ST_COMP: begin
        if (was_busy && !core_busy) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        fold = 1'b1;
        if (ret_idle) state_next = ST_IDLE;
        else if (final_blk) state_next = ST_OUT;
        else state_next = ST_PAD;
      end
      ST_OUT: begin
        if (!out_stall && oidx == 3'd7) begin
          reinit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      bits <= '0;
      pidx <= '0;
      final_blk <= 1'b0;
      ret_idle <= 1'b0;
      oidx <= '0;
      was_busy <= 1'b0;
    end else begin
      state <= state_next;
      was_busy <= core_busy;
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (byte_valid) begin
              fill <= fill + 6'd1;
              bits <= bits + 64'd8;
            end
            ret_idle <= !end_of_message;
            if (end_of_message) begin
              // pad starts at the mark position; a full block pads from 0
              if (byte_valid && fill == 6'd63) begin
                pidx <= '0;
                fill <= '0;
                final_blk <= 1'b0;
              end else begin
                pidx <= {1'b0, fill + (byte_valid ? 6'd1 : 6'd0)};
                fill <= fill + (byte_valid ? 6'd1 : 6'd0);
                final_blk <= ((fill + (byte_valid ? 6'd1 : 6'd0)) < PadPos);
              end
            end
          end
        end
        ST_PAD: pidx <= pidx + 7'd1;
        ST_FOLD: begin
          if (!ret_idle && !final_blk) begin
            final_blk <= 1'b1;
            pidx <= '0;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              fill <= '0;
              bits <= '0;
              final_blk <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
